// File: src/pca_pkg.sv
// Shared types and constants for the palette color allocator.
package pca_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int SHIFT_W    = 5;
    localparam int S_TDATA_W  = 128;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 88;
    localparam int M_TUSER_W  = 3;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 16;
    localparam int PIXEL_W    = 32;
    localparam int DIST_W     = 25;

    localparam int COLOR_FULL = 65535;
    localparam int ALPHA_FULL = 255;

    localparam logic [DIST_W-1:0]  DIST_INIT_COLOR = DIST_W'(256 * 256 * 256);
    localparam logic [DIST_W-1:0]  DIST_INIT_GRAY  = DIST_W'(256);
    localparam logic [BYTE_W-1:0]  ALPHA_OPAQUE    = 8'hFF;

    localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 5'd16;
    localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 5'd8;
    localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 5'd0;
    localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 5'd24;

    typedef enum logic [1:0] {
        CMD_TO_PIXEL = 2'd0,
        CMD_TO_COLOR = 2'd1,
        CMD_LOAD     = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_HIT       = 3'd0,
        STAT_ALLOC     = 3'd1,
        STAT_NEAREST   = 3'd2,
        STAT_PACKED    = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_LOADED    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CFG_PALETTE_ON  = 3'd0,
        CFG_GRAY_MODE   = 3'd1,
        CFG_RED_SHIFT   = 3'd2,
        CFG_GREEN_SHIFT = 3'd3,
        CFG_BLUE_SHIFT  = 3'd4,
        CFG_ALPHA_SHIFT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_LOOKUP,
        ST_RESULT
    } state_t;

endpackage

// File: src/palette_color_allocator.sv
// Palette color allocator: lookup, allocation and nearest match over a palette memory.
//
// One beat in, one beat out. A color-to-pixel beat in palette mode scans the whole
// single-port palette memory, one entry per cycle, through a four-stage match and
// distance pipeline, before the next beat is accepted; every other command goes straight
// to the result, a palette read-back through the lookup state first.
// The exact match, the first free entry and the nearest entry are all found in that
// one pass; an allocation is written back after it. Used flags sit in flip-flops and
// clear at reset, so there is no clearing pass. Configuration writes take effect at
// once and are meant to arrive only while the block is idle.
module palette_color_allocator #(
    parameter int NUM_ENTRIES  = 256,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // in_red, in_green, in_blue, in_alpha, in_pixel, load_index, load_red,
    // load_green, load_blue, load_used, zero pad
    input  logic [pca_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [pca_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_pixel, out_red, out_green, out_blue, out_alpha
    output logic [pca_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [pca_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pca_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pca_pkg::*;

    localparam int IDX_W     = $clog2(NUM_ENTRIES);
    localparam int CNT_W     = $clog2(NUM_ENTRIES + 1);
    localparam int CHAN_MASK = (1 << CHANNEL_BITS) - 1;
    localparam int LEVELS    = 1 << CHANNEL_BITS;
    localparam int MEM_W     = 3 * COLOR_W;
    localparam logic [BYTE_W-1:0] CHAN_MASK_B = BYTE_W'(CHAN_MASK);

    function automatic logic [BYTE_W-1:0] absdiff(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // configuration
    logic               palette_on_reg;
    logic               gray_mode_reg;
    logic [SHIFT_W-1:0] red_shift_reg;
    logic [SHIFT_W-1:0] green_shift_reg;
    logic [SHIFT_W-1:0] blue_shift_reg;
    logic [SHIFT_W-1:0] alpha_shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_on_reg  <= 1'b1;
            gray_mode_reg   <= 1'b0;
            red_shift_reg   <= RED_SHIFT_RST;
            green_shift_reg <= GREEN_SHIFT_RST;
            blue_shift_reg  <= BLUE_SHIFT_RST;
            alpha_shift_reg <= ALPHA_SHIFT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PALETTE_ON:  palette_on_reg  <= cfg_data[0];
                CFG_GRAY_MODE:   gray_mode_reg   <= cfg_data[0];
                CFG_RED_SHIFT:   red_shift_reg   <= cfg_data[SHIFT_W-1:0];
                CFG_GREEN_SHIFT: green_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_BLUE_SHIFT:  blue_shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_ALPHA_SHIFT: alpha_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // state
    state_t state_reg, state_next;
    logic   s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // captured beat
    logic [S_TUSER_W-1:0] cmd_reg;
    logic [BYTE_W-1:0]    r_reg, g_reg, b_reg, a_reg;
    logic [PIXEL_W-1:0]   pix_reg;
    logic [BYTE_W-1:0]    ld_idx_reg;
    logic [COLOR_W-1:0]   ld_r_reg, ld_g_reg, ld_b_reg;
    logic                 ld_used_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg     <= s_tuser;
            r_reg       <= s_tdata[7:0];
            g_reg       <= s_tdata[15:8];
            b_reg       <= s_tdata[23:16];
            a_reg       <= s_tdata[31:24];
            pix_reg     <= s_tdata[63:32];
            ld_idx_reg  <= s_tdata[71:64];
            ld_r_reg    <= s_tdata[87:72];
            ld_g_reg    <= s_tdata[103:88];
            ld_b_reg    <= s_tdata[119:104];
            ld_used_reg <= s_tdata[120];
        end
    end

    // byte-replicated search color; gray mode copies red into all channels
    logic [COLOR_W-1:0] r1, g1, b1;
    assign r1 = {r_reg, r_reg};
    assign g1 = gray_mode_reg ? r1 : {g_reg, g_reg};
    assign b1 = gray_mode_reg ? r1 : {b_reg, b_reg};

    logic [IDX_W-1:0] pix_idx, ld_addr;
    logic             pix_in_range, ld_in_range;
    assign pix_idx      = pix_reg[IDX_W-1:0];
    assign ld_addr      = ld_idx_reg[IDX_W-1:0];
    assign pix_in_range = (pix_reg < PIXEL_W'(NUM_ENTRIES));
    assign ld_in_range  = ({1'b0, ld_idx_reg} < (BYTE_W + 1)'(NUM_ENTRIES));

    // packed mode
    logic [PIXEL_W-1:0] packed_pixel;
    assign packed_pixel = (PIXEL_W'(r_reg & CHAN_MASK_B) << red_shift_reg)
                        | (PIXEL_W'(g_reg & CHAN_MASK_B) << green_shift_reg)
                        | (PIXEL_W'(b_reg & CHAN_MASK_B) << blue_shift_reg)
                        | (PIXEL_W'(a_reg & CHAN_MASK_B) << alpha_shift_reg);

    logic [PIXEL_W-1:0] red_sh, green_sh, blue_sh, alpha_sh;
    assign red_sh   = pix_reg >> red_shift_reg;
    assign green_sh = pix_reg >> green_shift_reg;
    assign blue_sh  = pix_reg >> blue_shift_reg;
    assign alpha_sh = pix_reg >> alpha_shift_reg;

    // rounded field-to-full-scale tables, built at elaboration
    logic [COLOR_W-1:0] scale_color_tbl [LEVELS];
    logic [BYTE_W-1:0]  scale_alpha_tbl [LEVELS];
    for (genvar f = 0; f < LEVELS; f++) begin : g_scale
        assign scale_color_tbl[f] = COLOR_W'((f * COLOR_FULL + CHAN_MASK / 2) / CHAN_MASK);
        assign scale_alpha_tbl[f] = BYTE_W'((f * ALPHA_FULL + CHAN_MASK / 2) / CHAN_MASK);
    end

    // palette memory: {blue, green, red}
    logic [MEM_W-1:0] pal_mem [NUM_ENTRIES];
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_addr;
    logic [MEM_W-1:0] mem_wdata;
    logic [MEM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pal_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= pal_mem[mem_addr];
        end
    end

    logic [NUM_ENTRIES-1:0] used_reg;
    logic [CNT_W-1:0]       used_count_reg;

    // scan bookkeeping
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              rd_vld_reg, d_vld_reg, p1_vld_reg, prod_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg, d_idx_reg, p1_idx_reg, prod_idx_reg;
    logic [BYTE_W-1:0] dr_reg, dg_reg, db_reg, p1_dr_reg, p1_db_reg;
    logic [2*BYTE_W-1:0] p1_reg;
    logic [DIST_W-2:0] prod_reg;
    logic              match_found_reg, free_found_reg;
    logic [IDX_W-1:0]  match_idx_reg, free_idx_reg, nearest_idx_reg;
    logic [DIST_W-1:0] best_reg;
    logic              alloc_go;

    assign alloc_go = !match_found_reg && (used_count_reg < CNT_W'(NUM_ENTRIES));

    logic out_load;
    logic m_tvalid_reg;
    assign out_load = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = scan_cnt_reg[IDX_W-1:0];
        mem_wdata  = {b1, g1, r1};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (cmd_reg)
                    CMD_TO_PIXEL: begin
                        state_next = palette_on_reg ? ST_SCAN : ST_RESULT;
                    end
                    CMD_TO_COLOR: begin
                        if (palette_on_reg && pix_in_range && used_reg[pix_idx]) begin
                            mem_re     = 1'b1;
                            mem_addr   = pix_idx;
                            state_next = ST_LOOKUP;
                        end else begin
                            state_next = ST_RESULT;
                        end
                    end
                    CMD_LOAD: begin
                        if (ld_in_range) begin
                            mem_we    = 1'b1;
                            mem_addr  = ld_addr;
                            mem_wdata = {ld_b_reg, ld_g_reg, ld_r_reg};
                        end
                        state_next = ST_RESULT;
                    end
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_SCAN: begin
                mem_re = 1'b1;
                if (scan_cnt_reg == CNT_W'(NUM_ENTRIES - 1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!(rd_vld_reg || d_vld_reg || p1_vld_reg || prod_vld_reg)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (alloc_go) begin
                    mem_we   = 1'b1;
                    mem_addr = free_idx_reg;
                end
                state_next = ST_RESULT;
            end
            ST_LOOKUP: state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // used flags and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            used_count_reg <= '0;
        end else if (state_reg == ST_EXEC && cmd_reg == CMD_LOAD && ld_in_range) begin
            used_reg[ld_addr] <= ld_used_reg;
            if (ld_used_reg && !used_reg[ld_addr]) begin
                used_count_reg <= used_count_reg + CNT_W'(1);
            end else if (!ld_used_reg && used_reg[ld_addr]) begin
                used_count_reg <= used_count_reg - CNT_W'(1);
            end
        end else if (state_reg == ST_DECIDE && alloc_go) begin
            used_reg[free_idx_reg] <= 1'b1;
            used_count_reg         <= used_count_reg + CNT_W'(1);
        end
    end

    // scan pipeline: read -> match/free + diffs -> r*g -> *b -> min
    logic [COLOR_W-1:0] rd_red, rd_green, rd_blue;
    logic               rd_used, rd_hit;
    assign rd_red   = rd_data_reg[COLOR_W-1:0];
    assign rd_green = rd_data_reg[2*COLOR_W-1:COLOR_W];
    assign rd_blue  = rd_data_reg[3*COLOR_W-1:2*COLOR_W];
    assign rd_used  = used_reg[rd_idx_reg];
    assign rd_hit   = rd_used && (rd_red == r1)
                   && (gray_mode_reg || (rd_green == g1 && rd_blue == b1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg      <= 1'b0;
            d_vld_reg       <= 1'b0;
            p1_vld_reg      <= 1'b0;
            prod_vld_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            scan_cnt_reg    <= '0;
        end else begin
            rd_vld_reg   <= (state_reg == ST_SCAN);
            d_vld_reg    <= rd_vld_reg;
            p1_vld_reg   <= d_vld_reg;
            prod_vld_reg <= p1_vld_reg;
            if (state_reg == ST_EXEC) begin
                scan_cnt_reg    <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end else begin
                if (state_reg == ST_SCAN) scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                if (rd_vld_reg && !match_found_reg && rd_hit) match_found_reg <= 1'b1;
                if (rd_vld_reg && !free_found_reg && !rd_used) free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= scan_cnt_reg[IDX_W-1:0];
        d_idx_reg    <= rd_idx_reg;
        dr_reg       <= absdiff(rd_red[BYTE_W-1:0], r_reg);
        dg_reg       <= absdiff(rd_green[BYTE_W-1:0], g_reg);
        db_reg       <= absdiff(rd_blue[BYTE_W-1:0], b_reg);
        p1_idx_reg   <= d_idx_reg;
        p1_reg       <= (2 * BYTE_W)'(dr_reg) * (2 * BYTE_W)'(dg_reg);
        p1_dr_reg    <= dr_reg;
        p1_db_reg    <= db_reg;
        prod_idx_reg <= p1_idx_reg;
        prod_reg     <= gray_mode_reg ? (DIST_W - 1)'(p1_dr_reg)
                                      : (DIST_W - 1)'(p1_reg) * (DIST_W - 1)'(p1_db_reg);

        if (state_reg == ST_EXEC) begin
            best_reg <= gray_mode_reg ? DIST_INIT_GRAY : DIST_INIT_COLOR;
        end else begin
            if (rd_vld_reg && !match_found_reg && rd_hit) match_idx_reg <= rd_idx_reg;
            if (rd_vld_reg && !free_found_reg && !rd_used) free_idx_reg <= rd_idx_reg;
            // strict compare keeps the lowest index on a tie
            if (prod_vld_reg && ({1'b0, prod_reg} < best_reg)) begin
                best_reg        <= {1'b0, prod_reg};
                nearest_idx_reg <= prod_idx_reg;
            end
        end
    end

    // result assembly
    logic [PIXEL_W-1:0] res_pixel_reg;
    logic [COLOR_W-1:0] res_red_reg, res_green_reg, res_blue_reg;
    logic [BYTE_W-1:0]  res_alpha_reg;
    status_t            res_status_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_EXEC: begin
                res_pixel_reg  <= '0;
                res_red_reg    <= '0;
                res_green_reg  <= '0;
                res_blue_reg   <= '0;
                res_alpha_reg  <= '0;
                res_status_reg <= STAT_NOT_FOUND;
                unique case (cmd_reg)
                    CMD_TO_PIXEL: begin
                        if (!palette_on_reg) begin
                            res_pixel_reg  <= packed_pixel;
                            res_status_reg <= STAT_PACKED;
                        end
                    end
                    CMD_TO_COLOR: begin
                        if (palette_on_reg) begin
                            res_alpha_reg <= ALPHA_OPAQUE;
                        end else begin
                            res_red_reg    <= scale_color_tbl[red_sh[CHANNEL_BITS-1:0]];
                            res_green_reg  <= scale_color_tbl[green_sh[CHANNEL_BITS-1:0]];
                            res_blue_reg   <= scale_color_tbl[blue_sh[CHANNEL_BITS-1:0]];
                            res_alpha_reg  <= scale_alpha_tbl[alpha_sh[CHANNEL_BITS-1:0]];
                            res_status_reg <= STAT_PACKED;
                        end
                    end
                    CMD_LOAD: begin
                        res_pixel_reg <= PIXEL_W'(ld_idx_reg);
                        if (ld_in_range) res_status_reg <= STAT_LOADED;
                    end
                    default: ;
                endcase
            end
            ST_LOOKUP: begin
                res_red_reg    <= rd_red;
                res_green_reg  <= rd_green;
                res_blue_reg   <= rd_blue;
                res_status_reg <= STAT_HIT;
            end
            ST_DECIDE: begin
                if (match_found_reg) begin
                    res_pixel_reg  <= PIXEL_W'(match_idx_reg);
                    res_status_reg <= STAT_HIT;
                end else if (alloc_go) begin
                    res_pixel_reg  <= PIXEL_W'(free_idx_reg);
                    res_status_reg <= STAT_ALLOC;
                end else begin
                    res_pixel_reg  <= PIXEL_W'(nearest_idx_reg);
                    res_status_reg <= STAT_NEAREST;
                end
            end
            default: ;
        endcase
    end

    // output register
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic [COLOR_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic [BYTE_W-1:0]  out_alpha_reg;
    status_t            out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_pixel_reg  <= res_pixel_reg;
            out_red_reg    <= res_red_reg;
            out_green_reg  <= res_green_reg;
            out_blue_reg   <= res_blue_reg;
            out_alpha_reg  <= res_alpha_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_alpha_reg, out_blue_reg, out_green_reg, out_red_reg, out_pixel_reg};
    assign m_tuser  = out_status_reg;

endmodule

// File: src/pca_checker.sv
// Port-level checks for the palette color allocator, bound to the top level.
module pca_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pca_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pca_pkg::M_TUSER_W-1:0] m_tuser
);
    import pca_pkg::*;

    // one item at a time: an accepted beat closes the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready right after an accepted beat");

    // a new result only appears after the block has been busy
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while the input side was idle");

    // allocation, nearest-match and load results carry no color; a load index fits in a byte
    a_index_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_ALLOC || m_tuser == STAT_NEAREST
                      || m_tuser == STAT_LOADED))
        |-> (m_tdata[M_TDATA_W-1:PIXEL_W] == '0)
         && (m_tuser != STAT_LOADED || m_tdata[PIXEL_W-1:BYTE_W] == '0))
        else $error("index result carries color bits or a wide index");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind palette_color_allocator pca_checker u_pca_checker (.*);
